@@ sv/atbc_pkg.sv @@
// shared constants, register codes and state types for the beat counter
`default_nettype none

package atbc_pkg;

  // window geometry
  localparam int WINDOW    = 500;
  localparam int RECOMPUTE = 100;
  localparam int ADDR_W    = $clog2(WINDOW);
  localparam int RC_W      = (RECOMPUTE > 1) ? $clog2(RECOMPUTE) : 1;

  // field widths
  localparam int TIME_W     = 32;
  localparam int SMP_W      = 12;
  localparam int PCT_W      = 7;
  localparam int PERIOD_W   = 10;
  localparam int GAP_W      = 16;
  localparam int RPT_W      = 20;
  localparam int SCALE_W    = 6;
  localparam int BEAT_W     = 8;
  localparam int BPM_W      = 14;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  // threshold arithmetic: span * percent, then divide by 100 via reciprocal
  localparam int PCT_DIV     = 100;
  localparam int PROD_W      = SMP_W + PCT_W;
  localparam int DIV_SHIFT   = 26;
  localparam int DIV_RECIP_W = 20;
  localparam logic [DIV_RECIP_W-1:0] DIV_RECIP =
    DIV_RECIP_W'((2**DIV_SHIFT + PCT_DIV - 1) / PCT_DIV);
  localparam int QUO_W = 13;
  localparam logic [SMP_W-1:0] SMP_MAX = {SMP_W{1'b1}};
  localparam logic [BEAT_W-1:0] BEAT_MAX = {BEAT_W{1'b1}};

  // register reset values
  localparam logic [PCT_W-1:0]    RST_THRESHOLD_PERCENT = PCT_W'(65);
  localparam logic [PERIOD_W-1:0] RST_SAMPLE_PERIOD     = PERIOD_W'(50);
  localparam logic [SMP_W-1:0]    RST_CLIP_LEVEL        = SMP_W'(4090);
  localparam logic [GAP_W-1:0]    RST_MIN_GAP           = GAP_W'(300);
  localparam logic [GAP_W-1:0]    RST_MAX_GAP           = GAP_W'(2000);
  localparam logic [RPT_W-1:0]    RST_REPORT_PERIOD     = RPT_W'(10000);
  localparam logic [SCALE_W-1:0]  RST_RATE_SCALE        = SCALE_W'(6);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD_PERCENT = 3'd0,
    REG_SAMPLE_PERIOD     = 3'd1,
    REG_CLIP_LEVEL        = 3'd2,
    REG_MIN_GAP           = 3'd3,
    REG_MAX_GAP           = 3'd4,
    REG_REPORT_PERIOD     = 3'd5,
    REG_RATE_SCALE        = 3'd6
  } cfg_reg_t;

  // item sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SCAN_GO,
    ST_SCAN_WAIT,
    ST_PEAK,
    ST_RPT
  } top_state_t;

  // window scan unit states
  typedef enum logic [2:0] {
    SC_IDLE,
    SC_READ,
    SC_DRAIN,
    SC_MUL1,
    SC_MUL2,
    SC_SUM
  } scan_state_t;

endpackage

`default_nettype wire

@@ sv/atbc_ram.sv @@
// generic single write port, single read port ram with registered read
`default_nettype none

module atbc_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 500
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ sv/atbc_scan.sv @@
// window scan unit: walks the ring for max and nonzero min, then forms the threshold
`default_nettype none

module atbc_scan (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [atbc_pkg::PCT_W-1:0]   pct,
  output logic      [atbc_pkg::ADDR_W-1:0]  rd_addr,
  input  wire logic [atbc_pkg::SMP_W-1:0]   rd_data,
  output logic                              done,
  output logic      [atbc_pkg::SMP_W-1:0]   thr
);

  import atbc_pkg::*;

  scan_state_t state_r, state_nxt;

  logic [ADDR_W-1:0]                cnt_r;
  logic                             rd_vld_r;
  logic [SMP_W-1:0]                 hi_r;
  logic [SMP_W-1:0]                 lo_r;
  logic                             any_r;
  logic [SMP_W-1:0]                 base_r;
  logic [PROD_W-1:0]                prod_r;
  logic [QUO_W-1:0]                 quo_r;
  logic [SMP_W-1:0]                 lo_eff;
  logic [PROD_W+DIV_RECIP_W-1:0]    div_full;
  logic [SMP_W+1:0]                 sum;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      SC_IDLE:  if (start) state_nxt = SC_READ;
      SC_READ:  if (cnt_r == ADDR_W'(WINDOW - 1)) state_nxt = SC_DRAIN;
      SC_DRAIN: state_nxt = SC_MUL1;
      SC_MUL1:  state_nxt = SC_MUL2;
      SC_MUL2:  state_nxt = SC_SUM;
      SC_SUM:   state_nxt = SC_IDLE;
      default:  state_nxt = SC_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    rd_addr = cnt_r;
    done    = (state_r == SC_SUM);
  end

  // datapath pieces
  assign lo_eff   = any_r ? lo_r : hi_r;
  assign div_full = (PROD_W+DIV_RECIP_W)'(prod_r) * (PROD_W+DIV_RECIP_W)'(DIV_RECIP);
  assign sum      = {2'b00, base_r} + {1'b0, quo_r};
  assign thr      = (sum > {2'b00, SMP_MAX}) ? SMP_MAX : sum[SMP_W-1:0];

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= SC_IDLE;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= (state_r == SC_READ);
    end
  end

  // address walk and running max / nonzero min
  always_ff @(posedge clk) begin
    if (state_r == SC_IDLE && start) begin
      cnt_r <= '0;
      hi_r  <= '0;
      lo_r  <= SMP_MAX;
      any_r <= 1'b0;
    end else begin
      if (state_r == SC_READ) begin
        cnt_r <= cnt_r + ADDR_W'(1);
      end
      if (rd_vld_r) begin
        if (rd_data > hi_r) begin
          hi_r <= rd_data;
        end
        if (rd_data != '0 && rd_data < lo_r) begin
          lo_r  <= rd_data;
          any_r <= 1'b1;
        end
      end
    end
  end

  // span times percent, then divide by 100 through the reciprocal
  always_ff @(posedge clk) begin
    if (state_r == SC_MUL1) begin
      base_r <= lo_eff;
      prod_r <= PROD_W'(hi_r - lo_eff) * PROD_W'(pct);
    end
    if (state_r == SC_MUL2) begin
      quo_r <= div_full[DIV_SHIFT +: QUO_W];
    end
  end

endmodule

`default_nettype wire

@@ sv/adaptive_threshold_beat_counter.sv @@
// top level: item sequencer, peak and beat logic, configuration registers
//
// Adaptive-threshold beat counter. Each item carries a millisecond timestamp
// and a 12-bit sample and yields exactly one result item. The first WINDOW
// items prime the sample ring; after that a sample is stored only when the
// sample period has elapsed. Every RECOMPUTE stored samples (and at the end
// of priming) the threshold is rebuilt by a scan of the whole ring through
// the single read port of the window ram, one entry per cycle. An ordinary
// item passes the evaluate, peak and report steps before its result is
// loaded, and the next item is accepted once the report step is done; an
// item that triggers a rescan also waits in between for the scan to finish.
// A stalled result register holds the report step, so the following result
// cannot be loaded until the register is free.
// in_stall stays high while an item is in progress. A result waits in the
// output register, and the next item is accepted while it is held. The
// configuration port is always ready; write it only while the block is idle.
`default_nettype none

module adaptive_threshold_beat_counter (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // input items
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [atbc_pkg::TIME_W-1:0]       in_time_ms,
  input  wire logic [atbc_pkg::SMP_W-1:0]        in_sample,
  // result items
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   out_sample_taken,
  output logic                                   out_in_peak_out,
  output logic      [atbc_pkg::SMP_W-1:0]        out_threshold_now,
  output logic                                   out_rate_valid,
  output logic      [atbc_pkg::BPM_W-1:0]        out_beats_per_minute,
  // configuration writes
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [atbc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [atbc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  import atbc_pkg::*;

  top_state_t state_r, state_nxt;

  // configuration registers
  logic [PCT_W-1:0]    pct_r;
  logic [PERIOD_W-1:0] period_r;
  logic [SMP_W-1:0]    clip_r;
  logic [GAP_W-1:0]    min_gap_r;
  logic [GAP_W-1:0]    max_gap_r;
  logic [RPT_W-1:0]    rpt_r;
  logic [SCALE_W-1:0]  scale_r;

  // block state
  logic [ADDR_W-1:0]   wp_r;
  logic [RC_W-1:0]     rc_r;
  logic                prime_r;
  logic [TIME_W-1:0]   last_sample_r;
  logic [SMP_W-1:0]    thr_r;
  logic                in_peak_r;
  logic [TIME_W-1:0]   last_peak_r;
  logic                peak_seen_r;
  logic [BEAT_W-1:0]   beat_r;
  logic [TIME_W-1:0]   rpt_start_r;

  // current item
  logic [TIME_W-1:0]   time_r;
  logic [SMP_W-1:0]    smp_r;
  logic                taken_r;
  logic                due_r;

  // output register
  logic                out_valid_r;
  logic                out_taken_r;
  logic                out_peak_r;
  logic [SMP_W-1:0]    out_thr_r;
  logic                out_rv_r;
  logic [BPM_W-1:0]    out_bpm_r;

  // handshake and sequencer controls
  logic                in_acc;
  logic                out_free;
  logic                ram_we;
  logic                scan_start;
  logic                scan_done;
  logic [SMP_W-1:0]    scan_thr;
  logic [ADDR_W-1:0]   scan_addr;
  logic [SMP_W-1:0]    scan_data;

  // evaluation step signals
  logic [TIME_W-1:0]   samp_diff;
  logic [TIME_W-1:0]   rpt_diff;
  logic                take_ok;
  logic                store_en;
  logic                wp_wrap;
  logic [ADDR_W-1:0]   wp_adv;
  logic [RC_W-1:0]     rc_adv;
  logic                rescan;

  // peak step signals
  logic [TIME_W-1:0]   gap;
  logic                gap_ok;
  logic                rise;
  logic                fall;
  logic [BPM_W-1:0]    bpm;

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // sample spacing, report period and ring pointer advance
  assign samp_diff = time_r - last_sample_r;
  assign rpt_diff  = time_r - rpt_start_r;
  assign take_ok   = samp_diff >= {{(TIME_W-PERIOD_W){1'b0}}, period_r};
  assign store_en  = prime_r || take_ok;
  assign wp_wrap   = (wp_r == ADDR_W'(WINDOW - 1));
  assign wp_adv    = wp_wrap ? '0 : wp_r + ADDR_W'(1);
  assign rc_adv    = (wp_wrap || rc_r == RC_W'(RECOMPUTE - 1)) ? '0 : rc_r + RC_W'(1);
  assign rescan    = prime_r ? wp_wrap : (take_ok && rc_adv == '0);

  // peak detection and beat gap check
  assign gap    = time_r - last_peak_r;
  assign gap_ok = gap >= {{(TIME_W-GAP_W){1'b0}}, min_gap_r} &&
                  gap <= {{(TIME_W-GAP_W){1'b0}}, max_gap_r};
  assign rise   = smp_r > thr_r && smp_r < clip_r && !in_peak_r;
  assign fall   = smp_r < thr_r || smp_r >= clip_r;
  assign bpm    = BPM_W'(beat_r) * BPM_W'(scale_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:      if (in_acc) state_nxt = ST_EVAL;
      ST_EVAL:      state_nxt = rescan ? ST_SCAN_GO : ST_PEAK;
      ST_SCAN_GO:   state_nxt = ST_SCAN_WAIT;
      ST_SCAN_WAIT: if (scan_done) state_nxt = ST_PEAK;
      ST_PEAK:      state_nxt = ST_RPT;
      ST_RPT:       if (out_free) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall   = (state_r != ST_IDLE);
    ram_we     = (state_r == ST_EVAL) && store_en;
    scan_start = (state_r == ST_SCAN_GO);
  end

  // window ring
  atbc_ram #(
    .WIDTH (SMP_W),
    .DEPTH (WINDOW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (smp_r),
    .raddr (scan_addr),
    .rdata (scan_data)
  );

  // scan and threshold unit
  atbc_scan u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (scan_start),
    .pct     (pct_r),
    .rd_addr (scan_addr),
    .rd_data (scan_data),
    .done    (scan_done),
    .thr     (scan_thr)
  );

  // configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pct_r     <= RST_THRESHOLD_PERCENT;
      period_r  <= RST_SAMPLE_PERIOD;
      clip_r    <= RST_CLIP_LEVEL;
      min_gap_r <= RST_MIN_GAP;
      max_gap_r <= RST_MAX_GAP;
      rpt_r     <= RST_REPORT_PERIOD;
      scale_r   <= RST_RATE_SCALE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_THRESHOLD_PERCENT: pct_r     <= cfg_wdata[PCT_W-1:0];
        REG_SAMPLE_PERIOD:     period_r  <= cfg_wdata[PERIOD_W-1:0];
        REG_CLIP_LEVEL:        clip_r    <= cfg_wdata[SMP_W-1:0];
        REG_MIN_GAP:           min_gap_r <= cfg_wdata[GAP_W-1:0];
        REG_MAX_GAP:           max_gap_r <= cfg_wdata[GAP_W-1:0];
        REG_REPORT_PERIOD:     rpt_r     <= cfg_wdata[RPT_W-1:0];
        REG_RATE_SCALE:        scale_r   <= cfg_wdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (in_acc) begin
      time_r <= in_time_ms;
      smp_r  <= in_sample;
    end
  end

  // block state updates per step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      wp_r          <= '0;
      rc_r          <= '0;
      prime_r       <= 1'b1;
      last_sample_r <= '0;
      thr_r         <= '0;
      in_peak_r     <= 1'b0;
      last_peak_r   <= '0;
      peak_seen_r   <= 1'b0;
      beat_r        <= '0;
      rpt_start_r   <= '0;
      taken_r       <= 1'b0;
      due_r         <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        // store decision, pointer advance, report check
        ST_EVAL: begin
          taken_r <= !prime_r && take_ok;
          due_r   <= !prime_r && (rpt_diff >= {{(TIME_W-RPT_W){1'b0}}, rpt_r});
          if (store_en) begin
            wp_r <= wp_adv;
            rc_r <= rc_adv;
          end
          if (prime_r && wp_wrap) begin
            prime_r     <= 1'b0;
            rpt_start_r <= time_r;
          end
          if (!prime_r && take_ok) begin
            last_sample_r <= time_r;
          end
        end
        // new threshold from the scan unit
        ST_SCAN_WAIT: begin
          if (scan_done) begin
            thr_r <= scan_thr;
          end
        end
        // peak entry and exit, beat counting
        ST_PEAK: begin
          if (taken_r) begin
            if (rise) begin
              in_peak_r   <= 1'b1;
              last_peak_r <= time_r;
              peak_seen_r <= 1'b1;
              if (peak_seen_r && gap_ok && beat_r != BEAT_MAX) begin
                beat_r <= beat_r + BEAT_W'(1);
              end
            end else if (fall) begin
              in_peak_r <= 1'b0;
            end
          end
        end
        // report period end
        ST_RPT: begin
          if (out_free && due_r) begin
            beat_r      <= '0;
            rpt_start_r <= time_r;
          end
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_RPT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_RPT && out_free) begin
      out_taken_r <= taken_r;
      out_peak_r  <= in_peak_r;
      out_thr_r   <= thr_r;
      out_rv_r    <= due_r;
      out_bpm_r   <= due_r ? bpm : '0;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_sample_taken     = out_taken_r;
  assign out_in_peak_out      = out_peak_r;
  assign out_threshold_now    = out_thr_r;
  assign out_rate_valid       = out_rv_r;
  assign out_beats_per_minute = out_bpm_r;

endmodule

`default_nettype wire
